// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define QTE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m: check failed");
`define QTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m: check failed");
`else
`define QTE_ASSERT(lbl, clk, rst, prop)
`define QTE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Widths, stage counts and the CORDIC angle table for the quaternion core.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int OP_W          = 34;   // atan2 operand width
   localparam int ROOT_W        = 31;
   localparam int REM_W         = 62;
   localparam int SQ_STAGES     = 31;   // one root bit per stage
   localparam int CW            = 48;   // CORDIC datapath width
   localparam int ACC_W         = 25;   // angle accumulator, 1/32768 degree
   localparam int ANG_W         = 17;   // rounded angle, 1/128 degree
   localparam int NORM_STEPS    = 7;
   localparam int NORM_LOG      = 40;
   localparam int CORDIC_STAGES = 20;
   localparam int ATAN_LAT      = 2 + NORM_STEPS + CORDIC_STAGES + 1;
   localparam int PIPE_DEPTH    = 3 + SQ_STAGES + ATAN_LAT + 1;
   localparam int HALF_TURN     = 5898240;
   localparam int PITCH_MAX     = 11520;
   localparam int TURN_MAX      = 23040;

   typedef struct packed {
      logic signed [31:0]     s;
      logic                   clamp;
      logic signed [OP_W-1:0] yaw_y;
      logic signed [OP_W-1:0] yaw_x;
      logic signed [OP_W-1:0] roll_y;
      logic signed [OP_W-1:0] roll_x;
   } side_type;

   function automatic logic signed [ACC_W-1:0] stage_angle(input int i);
      logic signed [ACC_W-1:0] a;
      case (i)
         0:  a = 25'sd1474560;
         1:  a = 25'sd870484;
         2:  a = 25'sd459940;
         3:  a = 25'sd233473;
         4:  a = 25'sd117189;
         5:  a = 25'sd58652;
         6:  a = 25'sd29333;
         7:  a = 25'sd14667;
         8:  a = 25'sd7334;
         9:  a = 25'sd3667;
         10: a = 25'sd1833;
         11: a = 25'sd917;
         12: a = 25'sd458;
         13: a = 25'sd229;
         14: a = 25'sd115;
         15: a = 25'sd57;
         16: a = 25'sd29;
         17: a = 25'sd14;
         18: a = 25'sd7;
         19: a = 25'sd4;
         default: a = '0;
      endcase
      return a;
   endfunction

   // normalize shift amount per step: binary search, then two single-bit steps
   function automatic int norm_shift(input int j);
      int b;
      case (j)
         0: b = 32;
         1: b = 16;
         2: b = 8;
         3: b = 4;
         4: b = 2;
         default: b = 1;
      endcase
      return b;
   endfunction

   // shift when magnitude is below 2^norm_limit(j)
   function automatic int norm_limit(input int j);
      int l;
      if (j < NORM_STEPS - 1) l = NORM_LOG - norm_shift(j);
      else l = NORM_LOG;
      return l;
   endfunction

endpackage

// ===== hdl/qte_sqrt.sv =====
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_sqrt (
   input  logic                            clock,
   input  logic                            en,
   input  logic [qte_pkg::REM_W-1:0]       radicand,
   output logic [qte_pkg::ROOT_W-1:0]      root
);

   localparam int N = qte_pkg::SQ_STAGES;

   logic [qte_pkg::REM_W-1:0]  rem_c [0:N-1];
   logic [qte_pkg::ROOT_W-1:0] q_c   [0:N-1];
   logic [qte_pkg::REM_W-1:0]  rem_ff [0:N-2];
   logic [qte_pkg::ROOT_W-1:0] q_ff   [0:N-1];

   assign rem_c[0] = radicand;
   assign q_c[0]   = '0;

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam int K = N - 1 - i;
      logic [qte_pkg::REM_W-1:0]  trial;
      logic [qte_pkg::REM_W-1:0]  rem_in;
      logic [qte_pkg::ROOT_W-1:0] q_in;

      if (i > 0) begin : g_link
         assign rem_c[i] = rem_ff[i-1];
         assign q_c[i]   = q_ff[i-1];
      end

      always_comb begin
         trial = (qte_pkg::REM_W'(q_c[i]) << (K + 1)) + (qte_pkg::REM_W'(1) << (2 * K));
         if (rem_c[i] >= trial) begin
            rem_in = rem_c[i] - trial;
            q_in   = q_c[i] | (qte_pkg::ROOT_W'(1) << K);
         end else begin
            rem_in = rem_c[i];
            q_in   = q_c[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) q_ff[i] <= q_in;
      end

      if (i < N - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) rem_ff[i] <= rem_in;
         end
      end else begin : g_norem
         logic unused_rem;
         assign unused_rem = ^rem_in;
      end
   end

   assign root = q_ff[N-1];

endmodule

// ===== hdl/qte_atan2.sv =====
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined atan2: half-turn fold, magnitude, normalize, 20 CORDIC stages, round.
// ----------------------------------------------------------------------------
module qte_atan2 (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [qte_pkg::OP_W-1:0]     y_in,
   input  logic signed [qte_pkg::OP_W-1:0]     x_in,
   output logic signed [qte_pkg::ANG_W-1:0]    angle
);

   localparam int CW = qte_pkg::CW;
   localparam int AW = qte_pkg::ACC_W;
   localparam int NS = qte_pkg::NORM_STEPS;
   localparam int CS = qte_pkg::CORDIC_STAGES;

   // fold
   logic signed [CW-1:0] a_x_ff, a_y_ff, a_x_in, a_y_in;
   logic signed [AW-1:0] a_acc_ff, a_acc_in;
   logic                 a_zero_ff;

   always_comb begin
      a_x_in   = CW'(x_in);
      a_y_in   = CW'(y_in);
      a_acc_in = '0;
      if (x_in < 0) begin
         a_acc_in = (y_in >= 0) ? AW'(qte_pkg::HALF_TURN) : -AW'(qte_pkg::HALF_TURN);
         a_x_in   = -CW'(x_in);
         a_y_in   = -CW'(y_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff    <= a_x_in;
         a_y_ff    <= a_y_in;
         a_acc_ff  <= a_acc_in;
         a_zero_ff <= (x_in == 0) && (y_in == 0);
      end
   end

   // magnitude
   logic signed [CW-1:0] b_x_ff, b_y_ff;
   logic signed [AW-1:0] b_acc_ff;
   logic                 b_zero_ff;
   logic [CW-1:0]        b_m_ff, ay;

   always_comb begin
      ay = (a_y_ff < 0) ? CW'(-a_y_ff) : CW'(a_y_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_x_ff    <= a_x_ff;
         b_y_ff    <= a_y_ff;
         b_acc_ff  <= a_acc_ff;
         b_zero_ff <= a_zero_ff;
         b_m_ff    <= (CW'(a_x_ff) > ay) ? CW'(a_x_ff) : ay;
      end
   end

   // normalize
   logic signed [CW-1:0] n_x_ff [0:NS-1];
   logic signed [CW-1:0] n_y_ff [0:NS-1];
   logic signed [AW-1:0] n_acc_ff [0:NS-1];
   logic                 n_zero_ff [0:NS-1];
   logic [CW-1:0]        n_m_ff [0:NS-2];

   for (genvar j = 0; j < NS; j++) begin : g_norm
      localparam int B = qte_pkg::norm_shift(j);
      localparam int L = qte_pkg::norm_limit(j);
      logic signed [CW-1:0] px, py;
      logic signed [AW-1:0] pacc;
      logic                 pzero;
      logic [CW-1:0]        pm;
      logic                 do_shift;

      if (j == 0) begin : g_first
         assign px = b_x_ff;
         assign py = b_y_ff;
         assign pacc = b_acc_ff;
         assign pzero = b_zero_ff;
         assign pm = b_m_ff;
      end else begin : g_next
         assign px = n_x_ff[j-1];
         assign py = n_y_ff[j-1];
         assign pacc = n_acc_ff[j-1];
         assign pzero = n_zero_ff[j-1];
         assign pm = n_m_ff[j-1];
      end

      assign do_shift = pm < (CW'(1) << L);

      always_ff @(posedge clock) begin
         if (en) begin
            n_x_ff[j]    <= do_shift ? (px <<< B) : px;
            n_y_ff[j]    <= do_shift ? (py <<< B) : py;
            n_acc_ff[j]  <= pacc;
            n_zero_ff[j] <= pzero;
         end
      end

      if (j < NS - 1) begin : g_m
         always_ff @(posedge clock) begin
            if (en) n_m_ff[j] <= do_shift ? (pm << B) : pm;
         end
      end
   end

   // CORDIC vectoring
   logic signed [CW-1:0] c_x_ff [0:CS-2];
   logic signed [CW-1:0] c_y_ff [0:CS-2];
   logic signed [AW-1:0] c_acc_ff [0:CS-1];
   logic                 c_zero_ff [0:CS-1];

   for (genvar i = 0; i < CS; i++) begin : g_cordic
      logic signed [CW-1:0] px, py, dx, dy, x_in_c, y_in_c;
      logic signed [AW-1:0] pacc, acc_in;
      logic                 pzero;

      if (i == 0) begin : g_first
         assign px = n_x_ff[NS-1];
         assign py = n_y_ff[NS-1];
         assign pacc = n_acc_ff[NS-1];
         assign pzero = n_zero_ff[NS-1];
      end else begin : g_next
         assign px = c_x_ff[i-1];
         assign py = c_y_ff[i-1];
         assign pacc = c_acc_ff[i-1];
         assign pzero = c_zero_ff[i-1];
      end

      always_comb begin
         dx = px >>> i;
         dy = py >>> i;
         if (py >= 0) begin
            x_in_c = px + dy;
            y_in_c = py - dx;
            acc_in = pacc + qte_pkg::stage_angle(i);
         end else begin
            x_in_c = px - dy;
            y_in_c = py + dx;
            acc_in = pacc - qte_pkg::stage_angle(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            c_acc_ff[i]  <= acc_in;
            c_zero_ff[i] <= pzero;
         end
      end

      if (i < CS - 1) begin : g_xy
         always_ff @(posedge clock) begin
            if (en) begin
               c_x_ff[i] <= x_in_c;
               c_y_ff[i] <= y_in_c;
            end
         end
      end else begin : g_noxy
         logic unused_xy;
         assign unused_xy = ^{x_in_c, y_in_c};
      end
   end

   // round to 1/128 degree
   logic signed [AW-1:0] rnd;
   logic signed [qte_pkg::ANG_W-1:0] angle_ff;

   assign rnd = (c_acc_ff[CS-1] + AW'(128)) >>> 8;

   always_ff @(posedge clock) begin
      if (en) angle_ff <= c_zero_ff[CS-1] ? '0 : rnd[qte_pkg::ANG_W-1:0];
   end

   assign angle = angle_ff;

endmodule

// ===== hdl/quaternion_to_euler_angles_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Quaternion to pitch/yaw/roll in 1/128 degree, fully pipelined.
// ----------------------------------------------------------------------------
// channel  | direction | payload
// req_     | in        | quat_x, quat_y, quat_z, quat_w (Q1.15)
// rsp_     | out       | pitch_angle, yaw_angle, roll_angle, asin_clamped
//
// One item per cycle unless stalled; the path is 3 product/sum stages, 31 square
// root stages (one root bit each), 30 atan2 stages (fold, magnitude, 7
// normalize steps, 20 CORDIC stages, round) and the output register.
// Synchronous reset clears only the valid line. A stall at the output
// freezes the whole pipeline; req_ready drops in the same cycle.
`include "assert_macros.svh"

module quaternion_to_euler_angles_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic signed [15:0] rsp_roll_angle,
   output logic               rsp_asin_clamped
);

   localparam int OW = qte_pkg::OP_W;
   localparam int D  = qte_pkg::PIPE_DEPTH;
   localparam int NQ = qte_pkg::SQ_STAGES;
   localparam int NA = qte_pkg::ATAN_LAT;

   logic en;
   logic vld_ff [0:D-1];

   assign rsp_valid = vld_ff[D-1];
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < D; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 1: products
   logic signed [31:0] p_xx_ff, p_yy_ff, p_zz_ff, p_ww_ff, p_zx_ff;
   logic signed [31:0] p_wy_ff, p_zw_ff, p_xy_ff, p_wx_ff, p_zy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_xx_ff <= req_quat_x * req_quat_x;
         p_yy_ff <= req_quat_y * req_quat_y;
         p_zz_ff <= req_quat_z * req_quat_z;
         p_ww_ff <= req_quat_w * req_quat_w;
         p_zx_ff <= req_quat_z * req_quat_x;
         p_wy_ff <= req_quat_w * req_quat_y;
         p_zw_ff <= req_quat_z * req_quat_w;
         p_xy_ff <= req_quat_x * req_quat_y;
         p_wx_ff <= req_quat_w * req_quat_x;
         p_zy_ff <= req_quat_z * req_quat_y;
      end
   end

   // stage 2: sums and clamp
   localparam logic signed [OW-1:0] ONE_Q30 = OW'(1) <<< 30;
   logic signed [OW-1:0] s_raw;
   qte_pkg::side_type    side_in, side2_ff, side3_ff;

   always_comb begin
      s_raw = OW'(0) - ((OW'(p_zx_ff) - OW'(p_wy_ff)) <<< 1);
      side_in.clamp = 1'b0;
      side_in.s     = 32'(s_raw);
      if (s_raw > ONE_Q30) begin
         side_in.s     = 32'(ONE_Q30);
         side_in.clamp = 1'b1;
      end else if (s_raw < -ONE_Q30) begin
         side_in.s     = 32'(-ONE_Q30);
         side_in.clamp = 1'b1;
      end
      side_in.yaw_y  = (OW'(p_zw_ff) + OW'(p_xy_ff)) <<< 1;
      side_in.yaw_x  = OW'(p_zz_ff) - OW'(p_ww_ff) - OW'(p_xx_ff) + OW'(p_yy_ff);
      side_in.roll_y = (OW'(p_wx_ff) + OW'(p_zy_ff)) <<< 1;
      side_in.roll_x = OW'(p_xx_ff) + OW'(p_yy_ff) - OW'(p_zz_ff) - OW'(p_ww_ff);
   end

   // stage 3: s squared
   logic signed [63:0] sq_full;
   logic [60:0]        sq_ff;

   assign sq_full = side2_ff.s * side2_ff.s;

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side_in;
         side3_ff <= side2_ff;
         sq_ff    <= sq_full[60:0];
      end
   end

   // cosine term: floor_sqrt(2^60 - s^2)
   localparam logic [qte_pkg::REM_W-1:0] SQ_ONE = qte_pkg::REM_W'(1) << 60;
   logic [qte_pkg::REM_W-1:0]  radicand;
   logic [qte_pkg::ROOT_W-1:0] root;

   assign radicand = SQ_ONE - qte_pkg::REM_W'(sq_ff);

   qte_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (radicand),
      .root     (root)
   );

   // sideband alongside the root pipeline
   qte_pkg::side_type side_ff [0:NQ-1];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side3_ff;
         for (int i = 1; i < NQ; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   logic signed [OW-1:0] pitch_x;
   logic signed [qte_pkg::ANG_W-1:0] pitch_a, yaw_a, roll_a;

   assign pitch_x = OW'(signed'({1'b0, root}));

   qte_atan2 u_pitch (
      .clock (clock),
      .en    (en),
      .y_in  (OW'(side_ff[NQ-1].s)),
      .x_in  (pitch_x),
      .angle (pitch_a)
   );

   qte_atan2 u_yaw (
      .clock (clock),
      .en    (en),
      .y_in  (side_ff[NQ-1].yaw_y),
      .x_in  (side_ff[NQ-1].yaw_x),
      .angle (yaw_a)
   );

   qte_atan2 u_roll (
      .clock (clock),
      .en    (en),
      .y_in  (side_ff[NQ-1].roll_y),
      .x_in  (side_ff[NQ-1].roll_x),
      .angle (roll_a)
   );

   logic clamp_ff [0:NA-1];

   always_ff @(posedge clock) begin
      if (en) begin
         clamp_ff[0] <= side_ff[NQ-1].clamp;
         for (int i = 1; i < NA; i++) clamp_ff[i] <= clamp_ff[i-1];
      end
   end

   function automatic logic signed [15:0] sat_angle(
      input logic signed [qte_pkg::ANG_W-1:0] v,
      input int lim
   );
      logic signed [qte_pkg::ANG_W-1:0] r;
      if (v > qte_pkg::ANG_W'(lim)) r = qte_pkg::ANG_W'(lim);
      else if (v < -qte_pkg::ANG_W'(lim)) r = -qte_pkg::ANG_W'(lim);
      else r = v;
      return r[15:0];
   endfunction

   logic signed [15:0] pitch_sat;
   logic signed [14:0] pitch_ff;
   logic signed [15:0] yaw_ff, roll_ff;
   logic               clamp_out_ff;

   assign pitch_sat = sat_angle(pitch_a, qte_pkg::PITCH_MAX);

   always_ff @(posedge clock) begin
      if (en) begin
         pitch_ff     <= pitch_sat[14:0];
         yaw_ff       <= sat_angle(yaw_a, qte_pkg::TURN_MAX);
         roll_ff      <= sat_angle(roll_a, qte_pkg::TURN_MAX);
         clamp_out_ff <= clamp_ff[NA-1];
      end
   end

   assign rsp_pitch_angle  = pitch_ff;
   assign rsp_yaw_angle    = yaw_ff;
   assign rsp_roll_angle   = roll_ff;
   assign rsp_asin_clamped = clamp_out_ff;

   `QTE_ASSERT(a_out_range, clock, reset, !rsp_valid || (rsp_pitch_angle <= 15'sd11520 && rsp_pitch_angle >= -15'sd11520 && rsp_yaw_angle <= 16'sd23040 && rsp_yaw_angle >= -16'sd23040 && rsp_roll_angle <= 16'sd23040 && rsp_roll_angle >= -16'sd23040))
   `QTE_ASSERT(a_stall_blocks, clock, reset, !(rsp_valid && !rsp_ready) || !req_ready)
   `QTE_ASSERT(a_root_range, clock, reset, !vld_ff[NQ+2] || root <= (qte_pkg::ROOT_W'(1) << 30))
   `QTE_ASSERT_NEXT(a_enter, clock, reset, req_valid && req_ready, vld_ff[0])

endmodule
